>>> src/gmpc_pkg.sv
// Shared types, constants and codes for the grid minimum path cost block.
package gmpc_pkg;

  localparam int unsigned DefMaxRows   = 32;
  localparam int unsigned DefMaxCols   = 32;
  localparam int unsigned DefWeightBits = 8;

  localparam int unsigned CfgW   = 6;
  localparam int unsigned InW    = 8;
  localparam int unsigned CostW  = 20;
  localparam int unsigned OutW   = 18;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam logic [OutW-1:0] OutMax = '1;

  // Register indexes on the configuration port.
  localparam logic RegRows = 1'b0;
  localparam logic RegCols = 1'b1;

  // Relaxation phases for one cell.
  localparam logic [2:0] PhUp    = 3'd0;
  localparam logic [2:0] PhRight = 3'd1;
  localparam logic [2:0] PhDown  = 3'd2;
  localparam logic [2:0] PhLeft  = 3'd3;
  localparam logic [2:0] PhOwn   = 3'd4;
  localparam logic [2:0] PhWr    = 3'd5;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       load_we;
    logic       load_rst;
    logic       scan_rst;
    logic       scan_inc;
    logic       clr_we;
    logic       rlx_en;
    logic       sweep_rst;
    logic       res_we;
    logic [2:0] phase;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic changed;
  } status_t;

endpackage

>>> src/gmpc_if.sv
// Valid/ready channel interfaces for grid cells in and path costs out.
interface gmpc_in_if;
  logic                      valid;
  logic                      ready;
  logic [gmpc_pkg::InW-1:0]  cell_weight;
  logic                      last_cell;
  modport source (output valid, output cell_weight, output last_cell, input ready);
  modport sink (input valid, input cell_weight, input last_cell, output ready);
endinterface

interface gmpc_out_if;
  logic                      valid;
  logic                      ready;
  logic [gmpc_pkg::OutW-1:0] path_cost;
  modport source (output valid, output path_cost, input ready);
  modport sink (input valid, input path_cost, output ready);
endinterface

>>> src/gmpc_datapath.sv
// Datapath: weight and best cost memories, cell scan counters and relaxation.
module gmpc_datapath #(
  parameter int unsigned MAX_ROWS    = gmpc_pkg::DefMaxRows,
  parameter int unsigned MAX_COLS    = gmpc_pkg::DefMaxCols,
  parameter int unsigned WEIGHT_BITS = gmpc_pkg::DefWeightBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gmpc_pkg::cmd_t                cmd_i,
  input  logic [gmpc_pkg::CfgW-1:0]     rows_i,
  input  logic [gmpc_pkg::CfgW-1:0]     cols_i,
  input  logic [gmpc_pkg::InW-1:0]      weight_i,
  output gmpc_pkg::status_t             status_o,
  output logic [gmpc_pkg::OutW-1:0]     path_cost_o
);
  localparam int unsigned Cells = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned NW    = $clog2(Cells + 1);
  localparam int unsigned MaxD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned DW    = ($clog2(MaxD + 1) > 7) ? $clog2(MaxD + 1) : 7;
  localparam int unsigned XW    = ((AW > DW) ? AW : DW) + 1;
  localparam int unsigned CW    = gmpc_pkg::CostW;

  logic [DW-1:0]   rows_x, cols_x, r_eff, c_eff;
  logic [2*DW-1:0] prod;
  logic [NW-1:0]   n_cells;
  logic [NW-1:0]   load_idx_q;
  logic [AW-1:0]   idx_q;
  logic [DW-1:0]   row_q, col_q;
  logic [XW-1:0]   idx_x, c_x, n_x;
  logic [AW-1:0]   a_up, a_right, a_down, a_left, rd_addr;
  logic [3:0]      nb_ok;
  logic            rd_ok_q, rd_nb_q;
  logic [CW-1:0]   bmem_rd_q, min_q, w_ext, sum, cand, new_val, last_cost_q;
  logic [WEIGHT_BITS-1:0] w_in, w_rd_q;
  logic [15:0]     w16;
  logic            improve, changed_q, bwe;
  logic [CW-1:0]   bwd;
  logic [gmpc_pkg::OutW-1:0] path_cost_q;

  logic [WEIGHT_BITS-1:0] wmem [Cells];
  logic [CW-1:0]          bmem [Cells];

  // Clamp the dimensions to one up to the maxima.
  assign rows_x = DW'(rows_i);
  assign cols_x = DW'(cols_i);
  assign r_eff  = (rows_x == '0) ? DW'(1) : (rows_x > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : rows_x;
  assign c_eff  = (cols_x == '0) ? DW'(1) : (cols_x > DW'(MAX_COLS)) ? DW'(MAX_COLS) : cols_x;
  assign prod    = r_eff * c_eff;
  assign n_cells = prod[NW-1:0];

  assign w16  = 16'(weight_i);
  assign w_in = w16[WEIGHT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
    end else if (cmd_i.load_rst) begin
      load_idx_q <= '0;
    end else if (cmd_i.load_we) begin
      if (load_idx_q < n_cells) load_idx_q <= load_idx_q + NW'(1);
      else load_idx_q <= n_cells;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && (load_idx_q < n_cells)) wmem[load_idx_q[AW-1:0]] <= w_in;
    w_rd_q <= wmem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.scan_rst) begin
      idx_q <= '0;
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.scan_inc) begin
      idx_q <= idx_q + AW'(1);
      if (col_q == c_eff - DW'(1)) begin
        col_q <= '0;
        row_q <= row_q + DW'(1);
      end else begin
        col_q <= col_q + DW'(1);
      end
    end
  end

  assign idx_x   = XW'(idx_q);
  assign c_x     = XW'(c_eff);
  assign n_x     = XW'(n_cells);
  assign a_up    = AW'(idx_x - c_x);
  assign a_down  = AW'(idx_x + c_x);
  assign a_right = idx_q + AW'(1);
  assign a_left  = idx_q - AW'(1);
  assign nb_ok   = {col_q != '0, row_q != r_eff - DW'(1),
                    col_q != c_eff - DW'(1), row_q != '0};

  always_comb begin
    unique case (cmd_i.phase)
      gmpc_pkg::PhUp:    rd_addr = a_up;
      gmpc_pkg::PhRight: rd_addr = a_right;
      gmpc_pkg::PhDown:  rd_addr = a_down;
      gmpc_pkg::PhLeft:  rd_addr = a_left;
      default:           rd_addr = idx_q;
    endcase
  end

  assign w_ext   = CW'(w_rd_q);
  assign sum     = min_q + w_ext;
  assign cand    = (idx_q == '0) ? w_ext : ((min_q == '1) ? '1 : sum);
  assign improve = cmd_i.rlx_en && (cmd_i.phase == gmpc_pkg::PhWr) && (cand < bmem_rd_q);
  assign new_val = improve ? cand : bmem_rd_q;
  assign bwe     = cmd_i.clr_we || improve;
  assign bwd     = cmd_i.clr_we ? '1 : cand;

  always_ff @(posedge clk_i) begin
    if (bwe) bmem[idx_q] <= bwd;
    bmem_rd_q <= bmem[rd_addr];
    rd_nb_q   <= cmd_i.phase < gmpc_pkg::PhOwn;
    rd_ok_q   <= (cmd_i.phase < gmpc_pkg::PhOwn) && nb_ok[cmd_i.phase[1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.phase == gmpc_pkg::PhUp) min_q <= '1;
    else if (rd_nb_q && rd_ok_q && (bmem_rd_q < min_q)) min_q <= bmem_rd_q;
    if (cmd_i.rlx_en && (cmd_i.phase == gmpc_pkg::PhWr) && status_o.scan_last)
      last_cost_q <= new_val;
    if (cmd_i.res_we)
      path_cost_q <= (last_cost_q > CW'(gmpc_pkg::OutMax)) ? gmpc_pkg::OutMax
                                                           : last_cost_q[gmpc_pkg::OutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      changed_q <= 1'b0;
    end else if (cmd_i.sweep_rst) begin
      changed_q <= 1'b0;
    end else if (improve) begin
      changed_q <= 1'b1;
    end
  end

  assign status_o.scan_last = (idx_x == n_x - XW'(1));
  assign status_o.changed   = changed_q || improve;
  assign path_cost_o        = path_cost_q;

endmodule

>>> src/gmpc_ctrl.sv
// Controller: sequences loading, clearing, relaxation sweeps and the result.
module gmpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  gmpc_pkg::status_t  status_i,
  output gmpc_pkg::cmd_t     cmd_o
);
  gmpc_pkg::state_e state_q, state_d;
  logic [2:0]       phase_q, phase_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmpc_pkg::ST_LOAD;
      phase_q     <= gmpc_pkg::PhUp;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      gmpc_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_we = 1'b1;
          if (in_last_i) begin
            cmd_o.load_rst = 1'b1;
            cmd_o.scan_rst = 1'b1;
            state_d        = gmpc_pkg::ST_CLEAR;
          end
        end
      end
      gmpc_pkg::ST_CLEAR: begin
        cmd_o.clr_we   = 1'b1;
        cmd_o.scan_inc = 1'b1;
        if (status_i.scan_last) begin
          cmd_o.scan_rst  = 1'b1;
          cmd_o.sweep_rst = 1'b1;
          phase_d         = gmpc_pkg::PhUp;
          state_d         = gmpc_pkg::ST_SWEEP;
        end
      end
      gmpc_pkg::ST_SWEEP: begin
        cmd_o.rlx_en = 1'b1;
        if (phase_q == gmpc_pkg::PhWr) begin
          phase_d        = gmpc_pkg::PhUp;
          cmd_o.scan_inc = 1'b1;
          if (status_i.scan_last) begin
            cmd_o.scan_rst = 1'b1;
            if (status_i.changed) cmd_o.sweep_rst = 1'b1;
            else state_d = gmpc_pkg::ST_FINISH;
          end
        end else begin
          phase_d = phase_q + 3'd1;
        end
      end
      gmpc_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_we = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = gmpc_pkg::ST_LOAD;
        end
      end
      default: state_d = gmpc_pkg::ST_LOAD;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_we |-> !(out_valid_q && !out_ready_i)) else $error("result overwritten");
  a_last_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_last_i) |=> state_q == gmpc_pkg::ST_CLEAR)
    else $error("last cell did not start clear");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= gmpc_pkg::PhWr) else $error("phase out of range");
  a_sweep_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gmpc_pkg::ST_SWEEP && state_d != gmpc_pkg::ST_SWEEP)
      |-> (phase_q == gmpc_pkg::PhWr && status_i.scan_last && !status_i.changed))
    else $error("sweep left early");

endmodule

>>> src/grid_min_path_cost_top.sv
// Top level of the grid minimum path cost block: configuration and wiring.
//
//  Channel  Direction  Payload                     Handshake
//  in_i     sink       cell_weight[7:0], last_cell valid/ready
//  out_o    source     path_cost[17:0]             valid/ready
//  APB      slave      rows (0x0), cols (0x4)      psel/penable, pready tied high
//
// Cells load at one item per cycle into the weight memory. On the item marked
// last, the block first clears the best cost memory, then relaxes every cell
// in row-major sweeps, one step at a time through the single read port of the
// best cost memory (four neighbours, the cell itself, one write). Sweeps
// repeat until one makes no change, and then the result is registered, held
// off while an older result still waits; no item is accepted meanwhile.
// Reset returns the block to loading with rows and cols at one. A result that
// waits on out_o does not stop the next grid loading.
module grid_min_path_cost_top #(
  parameter int unsigned MAX_ROWS    = gmpc_pkg::DefMaxRows,
  parameter int unsigned MAX_COLS    = gmpc_pkg::DefMaxCols,
  parameter int unsigned WEIGHT_BITS = gmpc_pkg::DefWeightBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gmpc_in_if.sink                     in_i,
  gmpc_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmpc_pkg::PaddrW-1:0] paddr,
  input  logic [gmpc_pkg::PdataW-1:0] pwdata,
  output logic [gmpc_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  logic [gmpc_pkg::CfgW-1:0] rows_q, cols_q;
  gmpc_pkg::cmd_t    cmd;
  gmpc_pkg::status_t status;
  logic              wr_en;

  // A register is written in the access cycle of an APB write.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gmpc_pkg::CfgW'(1);
      cols_q <= gmpc_pkg::CfgW'(1);
    end else if (wr_en) begin
      if (paddr[2] == gmpc_pkg::RegRows) rows_q <= pwdata[gmpc_pkg::CfgW-1:0];
      else cols_q <= pwdata[gmpc_pkg::CfgW-1:0];
    end
  end

  assign prdata = (paddr[2] == gmpc_pkg::RegRows) ? gmpc_pkg::PdataW'(rows_q)
                                                  : gmpc_pkg::PdataW'(cols_q);

  gmpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_cell),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gmpc_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rows_i      (rows_q),
    .cols_i      (cols_q),
    .weight_i    (in_i.cell_weight),
    .status_o    (status),
    .path_cost_o (out_o.path_cost)
  );

endmodule

>>> sim/tb_grid_min_path_cost_top.sv
// Self-checking testbench for the grid minimum path cost block.
module tb_grid_min_path_cost_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CellCap   = gmpc_pkg::DefMaxRows * gmpc_pkg::DefMaxCols;
  localparam int unsigned RandItems = 1050;
  // Width of the first grid and the largest random dimension.
  localparam int unsigned FillCols  = 12;

  // Byte addresses of the two registers, four bytes apart.
  localparam logic [gmpc_pkg::PaddrW-1:0] AddrRows = {gmpc_pkg::RegRows, 2'b00};
  localparam logic [gmpc_pkg::PaddrW-1:0] AddrCols = {gmpc_pkg::RegCols, 2'b00};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gmpc_pkg::PaddrW-1:0] paddr = '0;
  logic [gmpc_pkg::PdataW-1:0] pwdata = '0;
  logic [gmpc_pkg::PdataW-1:0] prdata;
  logic pready;

  gmpc_in_if in_if ();
  gmpc_out_if out_if ();

  grid_min_path_cost_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if.sink),
    .out_o   (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // Our own copy of the block's state: the cell weights, the load position and
  // the raw register values exactly as written.
  logic [gmpc_pkg::InW-1:0]  grid_wt [CellCap];
  int unsigned               load_pos = 0;
  logic [gmpc_pkg::CfgW-1:0] rows_reg = gmpc_pkg::CfgW'(1);
  logic [gmpc_pkg::CfgW-1:0] cols_reg = gmpc_pkg::CfgW'(1);

  logic [gmpc_pkg::OutW-1:0] cost_q[$];
  int unsigned     err_cnt = 0;
  int unsigned     item_cnt = 0;
  bit              quiet = 1'b0;
  int unsigned     stall_left = 0;

  function automatic int unsigned clamp_dim(logic [gmpc_pkg::CfgW-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Least path sum from top-left to bottom-right, both end cells counted. The
  // cost map is relaxed until it settles, which gives the same minimum as a
  // priority-queue search.
  function automatic logic [gmpc_pkg::OutW-1:0] least_path_cost(int unsigned r,
                                                                int unsigned c);
    int unsigned best [CellCap];
    int unsigned cand;
    int unsigned idx;
    bit moved;
    for (int i = 0; i < r * c; i++) best[i] = 32'hFFFF_FFFF;
    best[0] = 32'(grid_wt[0]);
    do begin
      moved = 1'b0;
      for (int y = 0; y < r; y++) begin
        for (int x = 0; x < c; x++) begin
          idx = y * c + x;
          if (y > 0 && best[idx - c] != 32'hFFFF_FFFF) begin
            cand = best[idx - c] + 32'(grid_wt[idx]);
            if (cand < best[idx]) begin best[idx] = cand; moved = 1'b1; end
          end
          if (y + 1 < r && best[idx + c] != 32'hFFFF_FFFF) begin
            cand = best[idx + c] + 32'(grid_wt[idx]);
            if (cand < best[idx]) begin best[idx] = cand; moved = 1'b1; end
          end
          if (x > 0 && best[idx - 1] != 32'hFFFF_FFFF) begin
            cand = best[idx - 1] + 32'(grid_wt[idx]);
            if (cand < best[idx]) begin best[idx] = cand; moved = 1'b1; end
          end
          if (x + 1 < c && best[idx + 1] != 32'hFFFF_FFFF) begin
            cand = best[idx + 1] + 32'(grid_wt[idx]);
            if (cand < best[idx]) begin best[idx] = cand; moved = 1'b1; end
          end
        end
      end
    end while (moved);
    cand = best[r * c - 1];
    return (cand > gmpc_pkg::OutMax) ? gmpc_pkg::OutMax : cand[gmpc_pkg::OutW-1:0];
  endfunction

  // Mirror one accepted cell: load it if there is room, and on the last cell
  // queue the cost that the search must report.
  task automatic absorb_cell(logic [gmpc_pkg::InW-1:0] w, logic last);
    int unsigned r;
    int unsigned c;
    r = clamp_dim(rows_reg, gmpc_pkg::DefMaxRows);
    c = clamp_dim(cols_reg, gmpc_pkg::DefMaxCols);
    if (load_pos < r * c) begin
      grid_wt[load_pos] = w;
      load_pos++;
    end else begin
      load_pos = r * c;
    end
    if (last) begin
      cost_q = {cost_q, least_path_cost(r, c)};
      load_pos = 0;
    end
  endtask

  // Offer one cell, sometimes after a random gap, and hold it until accepted. The
  // valid stays high afterwards so that back-to-back cells need no toggle.
  task automatic send_cell(logic [gmpc_pkg::InW-1:0] w, logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cell_weight <= w;
    in_if.last_cell <= last;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_cell(w, last);
    item_cnt++;
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every queued cost, then for the block to be back idle.
  task automatic wait_drained();
    drop_valid();
    wait (cost_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [gmpc_pkg::PaddrW-1:0] addr,
                           logic [gmpc_pkg::PdataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrRows) rows_reg = data[gmpc_pkg::CfgW-1:0];
    else cols_reg = data[gmpc_pkg::CfgW-1:0];
  endtask

  task automatic set_dims(logic [gmpc_pkg::PdataW-1:0] r, logic [gmpc_pkg::PdataW-1:0] c);
    wait_drained();
    write_reg(AddrRows, r);
    write_reg(AddrCols, c);
  endtask

  // Send a grid of cnt cells, the last one marked, weights random or fixed.
  task automatic send_grid(int unsigned cnt, int fixed_w);
    logic [gmpc_pkg::InW-1:0] w;
    for (int i = 0; i < cnt; i++) begin
      w = (fixed_w < 0) ? gmpc_pkg::InW'($urandom) : gmpc_pkg::InW'(fixed_w);
      send_cell(w, i == cnt - 1);
    end
  endtask

  // The first grid uses every row and writes every cell that a later short
  // grid can read, so that no cell is read before it was written.
  task automatic test_full_grid();
    set_dims(gmpc_pkg::DefMaxRows, FillCols);
    send_grid(gmpc_pkg::DefMaxRows * FillCols, -1);
  endtask

  // Extreme weights on a single cell and on a single row and column.
  task automatic test_extremes();
    set_dims(1, 1);
    send_grid(1, 0);
    send_grid(1, 255);
    set_dims(1, gmpc_pkg::DefMaxCols);
    send_grid(gmpc_pkg::DefMaxCols, 255);
    set_dims(gmpc_pkg::DefMaxRows, 1);
    send_grid(gmpc_pkg::DefMaxRows, 0);
  endtask

  // Zero and oversized dimensions are clamped; upper data bits are dropped.
  task automatic test_clamping();
    set_dims(0, 0);
    send_grid(1, -1);
    set_dims(63, 1);
    send_grid(gmpc_pkg::DefMaxRows, -1);
    set_dims(32'hFFFF_FF42, 3);
    send_grid(6, -1);
  endtask

  // Cells beyond the grid are ignored; an early last cell keeps old weights.
  task automatic test_extra_and_short();
    set_dims(2, 2);
    send_grid(7, -1);
    send_grid(2, -1);
    send_grid(1, 255);
  endtask

  task automatic test_random();
    int unsigned r;
    int unsigned c;
    int unsigned cnt;
    int unsigned grids;
    grids = 0;
    while (item_cnt < RandItems) begin
      if (item_cnt > RandItems * 85 / 100) quiet = 1'b1;
      if (grids % 6 == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          r = $urandom_range(1, FillCols);
          c = $urandom_range(1, FillCols);
        end else begin
          r = $urandom_range(1, 5);
          c = $urandom_range(1, 5);
        end
        set_dims(r, c);
      end
      r = clamp_dim(rows_reg, gmpc_pkg::DefMaxRows);
      c = clamp_dim(cols_reg, gmpc_pkg::DefMaxCols);
      case ($urandom_range(0, 9))
        0: cnt = r * c + $urandom_range(1, 4);
        1: cnt = $urandom_range(1, r * c);
        default: cnt = r * c;
      endcase
      send_grid(cnt, -1);
      grids++;
    end
  endtask

  // Result sink: random stall bursts, no new one once the quiet tail has begun.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Each accepted cost is compared with the oldest one predicted.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (cost_q.size() == 0) begin
        $error("path_cost: none expected, actual %0d", out_if.path_cost);
        err_cnt++;
      end else begin
        if (out_if.path_cost !== cost_q[0]) begin
          $error("path_cost: expected %0d, actual %0d", cost_q[0], out_if.path_cost);
          err_cnt++;
        end
        void'(cost_q.pop_front());
      end
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.cell_weight <= '0;
    in_if.last_cell <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_grid();
    test_extremes();
    test_clamping();
    test_extra_and_short();
    test_random();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && cost_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung search or handshake.
  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
src/gmpc_pkg.sv
src/gmpc_if.sv
src/gmpc_datapath.sv
src/gmpc_ctrl.sv
src/grid_min_path_cost_top.sv
sim/tb_grid_min_path_cost_top.sv
